@@ hw/rtl/bcdclk_pkg.sv @@
// Types and constants shared by the BCD clock with alarm.
`timescale 1ns / 1ps
`default_nettype none

package bcdclk_pkg;

  typedef enum logic [1:0] {
    KIND_TICK      = 2'd0,
    KIND_SET_TIME  = 2'd1,
    KIND_SET_ALARM = 2'd2,
    KIND_TOGGLE    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [21:0] set_value;
  } in_word_t;

  typedef struct packed {
    logic [21:0] time_now;
    logic        time_valid;
    logic        alarm_on;
    logic        alarm_fired;
  } out_word_t;

  typedef struct packed {
    logic inc;
    logic clr;
    logic load;
  } cell_ctl_t;

  localparam logic [15:0] TpsReset = 16'd1000;

endpackage

`default_nettype wire

@@ hw/rtl/bcdclk_prescale.sv @@
// Tick prescaler and ticks-per-second register.
`timescale 1ns / 1ps
`default_nettype none

module bcdclk_prescale
  import bcdclk_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tick_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             sec_o
);

  logic [15:0] tps_q;
  logic [15:0] cnt_q, cnt_d, cnt_inc;

  assign cnt_inc = cnt_q + 16'd1;
  assign sec_o   = tick_i && (cnt_inc == tps_q);

  always_comb begin
    cnt_d = cnt_q;
    if (tick_i) begin
      cnt_d = sec_o ? 16'd0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TpsReset;
      cnt_q <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_data_i;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bcdclk_digit.sv @@
// One BCD digit cell of the time cascade.
`timescale 1ns / 1ps
`default_nettype none

module bcdclk_digit
  import bcdclk_pkg::*;
#(
  parameter int unsigned W    = 4,
  parameter int unsigned Last = 9
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cell_ctl_t    ctl_i,
  input  wire logic [W-1:0] load_val_i,
  output logic [W-1:0]      q_o,
  output logic [W-1:0]      d_o,
  output logic              wrap_o
);

  logic [W-1:0] q_q, q_d;
  logic         at_last;

  assign at_last = (q_q >= W'(Last));
  assign wrap_o  = ctl_i.inc && at_last;

  always_comb begin
    q_d = q_q;
    if (ctl_i.load) begin
      q_d = load_val_i;
    end else if (ctl_i.clr) begin
      q_d = '0;
    end else if (ctl_i.inc) begin
      q_d = at_last ? '0 : q_q + W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;
  assign d_o = q_d;

endmodule

`default_nettype wire

@@ hw/rtl/bcd_clock_with_alarm.sv @@
// Top level of the six-digit BCD clock with alarm.
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one word per command:
//   tick, set time, set alarm or toggle alarm enable.
//   out channel (out_valid_o/out_ready_i/out_data_o) returns one word per
//   command: time after the command, valid and enable flags, and a fired
//   flag when a tick crossed into the enabled alarm minute.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes ticks per
//   second and is always ready; the user must write it only while idle, as the block does not check.
// Result: a command's result word is valid in the cycle after the command is accepted.
// Throughput: one command per cycle while no stall holds the output; the digit
//   cells and their carry chain update in the accept cycle.
// Stall: the output register holds its word while out_ready_i is low, and
//   in_ready_o drops until that word is taken or taken in the same cycle.
// Reset: time, alarm, flags and prescaler clear; ticks per second is 1000.
`timescale 1ns / 1ps
`default_nettype none

module bcd_clock_with_alarm
  import bcdclk_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_word_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_word_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  logic      acc;
  logic      tick, sec, load_time;
  logic      out_valid_q;
  out_word_t out_q;
  logic      valid_q, valid_d, enable_q, enable_d, fired;
  logic [13:0] alarm_q, alarm_d;

  logic [3:0] su_q, su_d, st_q, st_d, mu_q, mu_d, mt_q, mt_d, hu_q, hu_d;
  logic [1:0] ht_q, ht_d;
  logic       su_wrap, st_wrap, mu_wrap, mt_wrap, hu_wrap, ht_wrap;
  logic       hour_wrap;
  cell_ctl_t  su_ctl, st_ctl, mu_ctl, mt_ctl, hu_ctl, ht_ctl;
  logic [21:0] time_d;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign acc         = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign tick        = acc && (in_data_i.kind == KIND_TICK);
  assign load_time   = acc && (in_data_i.kind == KIND_SET_TIME);

  bcdclk_prescale u_prescale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .sec_o      (sec)
  );

  assign hour_wrap = mt_wrap && (ht_q >= 2'd2) && (hu_q >= 4'd3);

  assign su_ctl = '{inc: sec,                    clr: 1'b0,      load: load_time};
  assign st_ctl = '{inc: su_wrap,                clr: 1'b0,      load: load_time};
  assign mu_ctl = '{inc: st_wrap,                clr: 1'b0,      load: load_time};
  assign mt_ctl = '{inc: mu_wrap,                clr: 1'b0,      load: load_time};
  assign hu_ctl = '{inc: mt_wrap && !hour_wrap,  clr: hour_wrap, load: load_time};
  assign ht_ctl = '{inc: hu_wrap,                clr: hour_wrap, load: load_time};

  bcdclk_digit #(.W(4), .Last(9)) u_sec_units (
    .clk_i, .rst_ni, .ctl_i(su_ctl), .load_val_i(in_data_i.set_value[3:0]),
    .q_o(su_q), .d_o(su_d), .wrap_o(su_wrap)
  );
  bcdclk_digit #(.W(4), .Last(5)) u_sec_tens (
    .clk_i, .rst_ni, .ctl_i(st_ctl), .load_val_i(in_data_i.set_value[7:4]),
    .q_o(st_q), .d_o(st_d), .wrap_o(st_wrap)
  );
  bcdclk_digit #(.W(4), .Last(9)) u_min_units (
    .clk_i, .rst_ni, .ctl_i(mu_ctl), .load_val_i(in_data_i.set_value[11:8]),
    .q_o(mu_q), .d_o(mu_d), .wrap_o(mu_wrap)
  );
  bcdclk_digit #(.W(4), .Last(5)) u_min_tens (
    .clk_i, .rst_ni, .ctl_i(mt_ctl), .load_val_i(in_data_i.set_value[15:12]),
    .q_o(mt_q), .d_o(mt_d), .wrap_o(mt_wrap)
  );
  bcdclk_digit #(.W(4), .Last(9)) u_hour_units (
    .clk_i, .rst_ni, .ctl_i(hu_ctl), .load_val_i(in_data_i.set_value[19:16]),
    .q_o(hu_q), .d_o(hu_d), .wrap_o(hu_wrap)
  );
  bcdclk_digit #(.W(2), .Last(3)) u_hour_tens (
    .clk_i, .rst_ni, .ctl_i(ht_ctl), .load_val_i(in_data_i.set_value[21:20]),
    .q_o(ht_q), .d_o(ht_d), .wrap_o(ht_wrap)
  );

  assign time_d = {ht_d, hu_d, mt_d, mu_d, st_d, su_d};

  always_comb begin
    valid_d  = valid_q;
    enable_d = enable_q;
    alarm_d  = alarm_q;
    if (acc) begin
      case (in_data_i.kind)
        KIND_SET_TIME: valid_d = 1'b1;
        KIND_SET_ALARM: begin
          alarm_d  = in_data_i.set_value[21:8];
          enable_d = 1'b1;
        end
        KIND_TOGGLE: enable_d = !enable_q;
        default: ;
      endcase
    end
  end

  assign fired = sec && enable_q && (time_d[7:0] == 8'd0) && (time_d[21:8] == alarm_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      valid_q     <= 1'b0;
      enable_q    <= 1'b0;
      alarm_q     <= '0;
    end else begin
      valid_q  <= valid_d;
      enable_q <= enable_d;
      alarm_q  <= alarm_d;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= '{time_now: time_d, time_valid: valid_d, alarm_on: enable_d,
                 alarm_fired: fired};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.alarm_fired |-> out_q.alarm_on && (out_q.time_now[7:0] == 8'd0))
    else $error("alarm fired off a minute boundary or while disabled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_data_i.kind == KIND_SET_TIME) |=> out_valid_q && out_q.time_valid)
    else $error("set time did not mark time valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_data_i.kind == KIND_SET_ALARM) |=> out_q.alarm_on && enable_q)
    else $error("set alarm did not enable alarm");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_data_i.kind != KIND_TICK) |=> !out_q.alarm_fired)
    else $error("alarm fired on a non-tick word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ht_wrap && (!out_valid_q ||
      (out_q.time_now == {ht_q, hu_q, mt_q, mu_q, st_q, su_q})))
    else $error("digit cells disagree with the held output word");

endmodule

`default_nettype wire

@@ tb/sv/tb_bcd_clock_with_alarm.sv @@
// Self-checking testbench for the BCD clock with alarm.
`timescale 1ns / 1ps

module tb_bcd_clock_with_alarm;
  import bcdclk_pkg::*;

  localparam int CycleLimit = 1_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_word_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_word_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  bcd_clock_with_alarm dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // clock predictor state
  logic [15:0] rate_reg;
  logic [15:0] prescale;
  logic [3:0]  now_dig [6];
  logic [3:0]  alarm_dig [4];
  logic        time_set;
  logic        alarm_en;

  out_word_t   expected_words [$];
  bit          no_stall;
  int          ready_hold;
  int          cycles;
  int          mismatches;
  int          words_sent;
  int          words_checked;
  int          ticks_sent;
  int          seconds_advanced;
  int          alarms_fired;

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    if (no_stall) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic bit carry_digit(int i, logic [3:0] top);
    if (now_dig[i] >= top) begin
      now_dig[i] = 4'd0;
      return 1'b1;
    end
    now_dig[i] = now_dig[i] + 4'd1;
    return 1'b0;
  endfunction

  function automatic void next_second();
    if (carry_digit(5, 4'd9)) begin
      if (carry_digit(4, 4'd5)) begin
        if (carry_digit(3, 4'd9)) begin
          if (carry_digit(2, 4'd5)) begin
            if (now_dig[0] >= 4'd2 && now_dig[1] >= 4'd3) begin
              now_dig[0] = 4'd0;
              now_dig[1] = 4'd0;
            end else if (carry_digit(1, 4'd9)) begin
              now_dig[0] = (now_dig[0] + 4'd1) & 4'h3;
            end
          end
        end
      end
    end
  endfunction

  function automatic out_word_t clock_step(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.kind)
      KIND_TICK: begin
        prescale = prescale + 16'd1;
        if (prescale == rate_reg) begin
          prescale = 16'd0;
          next_second();
          seconds_advanced++;
          if (alarm_en && now_dig[4] == 4'd0 && now_dig[5] == 4'd0 &&
              now_dig[0] == alarm_dig[0] && now_dig[1] == alarm_dig[1] &&
              now_dig[2] == alarm_dig[2] && now_dig[3] == alarm_dig[3]) begin
            r.alarm_fired = 1'b1;
            alarms_fired++;
          end
        end
      end
      KIND_SET_TIME: begin
        now_dig[0] = {2'b00, w.set_value[21:20]};
        now_dig[1] = w.set_value[19:16];
        now_dig[2] = w.set_value[15:12];
        now_dig[3] = w.set_value[11:8];
        now_dig[4] = w.set_value[7:4];
        now_dig[5] = w.set_value[3:0];
        time_set = 1'b1;
      end
      KIND_SET_ALARM: begin
        alarm_dig[0] = {2'b00, w.set_value[21:20]};
        alarm_dig[1] = w.set_value[19:16];
        alarm_dig[2] = w.set_value[15:12];
        alarm_dig[3] = w.set_value[11:8];
        alarm_en = 1'b1;
      end
      default: begin
        alarm_en = !alarm_en;
      end
    endcase
    r.time_now = {now_dig[0][1:0], now_dig[1], now_dig[2], now_dig[3], now_dig[4],
                  now_dig[5]};
    r.time_valid = time_set;
    r.alarm_on = alarm_en;
    return r;
  endfunction

  function automatic logic [21:0] bcd_time(int hh, int mm, int ss);
    int q;
    logic [1:0] h_t;
    logic [3:0] h_u, m_t, m_u, s_t, s_u;
    q = hh / 10;
    h_t = q[1:0];
    q = hh % 10;
    h_u = q[3:0];
    q = mm / 10;
    m_t = q[3:0];
    q = mm % 10;
    m_u = q[3:0];
    q = ss / 10;
    s_t = q[3:0];
    q = ss % 10;
    s_u = q[3:0];
    return {h_t, h_u, m_t, m_u, s_t, s_u};
  endfunction

  function automatic logic [21:0] near_boundary();
    int hh, mm, ss, pick;
    pick = $urandom_range(0, 3);
    hh = (pick == 0) ? 23 : (pick == 1) ? 9 : (pick == 2) ? 19 : $urandom_range(0, 23);
    mm = ($urandom_range(0, 1) != 0) ? 59 : $urandom_range(0, 59);
    ss = $urandom_range(50, 59);
    return bcd_time(hh, mm, ss);
  endfunction

  task automatic send_word(input kind_e k, input logic [21:0] v);
    in_word_t w;
    int gap;
    w.kind = k;
    w.set_value = v;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    expected_words.push_back(clock_step(w));
    words_sent++;
    if (k == KIND_TICK) ticks_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(KIND_TICK, 22'($urandom));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [15:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rate_reg = v;
  endtask

  // bring the prescaler back to zero with a single tick
  task automatic realign_prescaler();
    write_rate(prescale + 16'd1);
    send_ticks(1);
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: word %h with nothing expected", $time, got);
      mismatches++;
    end else begin
      want = expected_words.pop_front();
      words_checked++;
      if (got.time_now !== want.time_now) begin
        $display("%0t: time_now expected %h actual %h", $time, want.time_now, got.time_now);
        mismatches++;
      end
      if (got.time_valid !== want.time_valid) begin
        $display("%0t: time_valid expected %b actual %b", $time, want.time_valid,
                 got.time_valid);
        mismatches++;
      end
      if (got.alarm_on !== want.alarm_on) begin
        $display("%0t: alarm_on expected %b actual %b", $time, want.alarm_on, got.alarm_on);
        mismatches++;
      end
      if (got.alarm_fired !== want.alarm_fired) begin
        $display("%0t: alarm_fired expected %b actual %b", $time, want.alarm_fired,
                 got.alarm_fired);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_word(out_data_o);
  end

  always @(posedge clk_i) begin
    if (no_stall) begin
      out_ready_i <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 2) != 0);
      ready_hold <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_bcd_clock_with_alarm NOT OK");
      $finish;
    end
  end

  task automatic test_default_rate();
    send_word(KIND_SET_TIME, bcd_time(12, 34, 56));
    send_ticks(20);
    realign_prescaler();
  endtask

  task automatic test_directed();
    write_rate(16'd1);
    send_ticks(1);
    send_word(KIND_TOGGLE, 22'h0);
    send_word(KIND_SET_TIME, bcd_time(23, 59, 59));
    send_ticks(1);
    send_word(KIND_TOGGLE, 22'h0);
    send_word(KIND_SET_ALARM, 22'h3FFFFF);
    send_word(KIND_SET_TIME, 22'h3FFFFF);
    send_ticks(1);
    send_word(KIND_SET_TIME, 22'h0);
    send_ticks(1);
    send_word(KIND_SET_ALARM, bcd_time(10, 0, 37));
    send_word(KIND_SET_TIME, bcd_time(9, 59, 59));
    send_ticks(1);
    send_word(KIND_SET_TIME, bcd_time(12, 59, 59));
    send_ticks(1);
    send_word(KIND_SET_TIME, bcd_time(19, 59, 59));
    send_ticks(1);
    send_word(KIND_SET_ALARM, bcd_time(23, 0, 0));
    send_word(KIND_SET_TIME, bcd_time(22, 59, 58));
    send_ticks(2);
    send_word(KIND_SET_TIME, bcd_time(22, 59, 59));
    send_word(KIND_TOGGLE, 22'h0);
    send_ticks(1);
    send_word(KIND_TOGGLE, 22'h0);
    send_word(KIND_SET_TIME, bcd_time(23, 0, 0));
  endtask

  task automatic test_prescaler_wrap();
    no_stall = 1'b1;
    write_rate(16'd65535);
    send_word(KIND_SET_TIME, bcd_time(23, 59, 59));
    send_ticks(5);
    write_rate(16'd2);
    send_ticks(20);
    write_rate(16'd0);
    send_ticks(20);
    realign_prescaler();
    no_stall = 1'b0;
  endtask

  task automatic random_step();
    int r, m, ss, n;
    logic [21:0] hm;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      n = (rate_reg != 0 && rate_reg <= 8) ? $urandom_range(1, 6 * rate_reg) :
          $urandom_range(1, 12);
      send_ticks(n);
    end else if (r < 65) begin
      send_word(KIND_SET_TIME, near_boundary());
    end else if (r < 80) begin
      m = $urandom_range(0, 1439);
      ss = $urandom_range(55, 59);
      hm = bcd_time(m / 60, m % 60, 0);
      send_word(KIND_SET_ALARM, {hm[21:8], 8'($urandom)});
      m = (m + 1439) % 1440;
      send_word(KIND_SET_TIME, bcd_time(m / 60, m % 60, ss));
      if (rate_reg != 0 && rate_reg <= 8) begin
        send_ticks((61 - ss) * rate_reg + $urandom_range(0, rate_reg));
      end
    end else if (r < 87) begin
      send_word(KIND_TOGGLE, 22'($urandom));
    end else if (r < 94) begin
      send_word(KIND_SET_TIME, 22'($urandom));
    end else begin
      send_word(KIND_SET_ALARM, 22'($urandom));
    end
  endtask

  task automatic test_random();
    logic [15:0] rates [6];
    int start;
    rates = '{16'd1, 16'd2, 16'd3, 16'd1, 16'd65535, 16'd1};
    rates[3] = 16'($urandom_range(4, 7));
    foreach (rates[p]) begin
      if (prescale >= rates[p]) realign_prescaler();
      write_rate(rates[p]);
      no_stall = (p == 5);
      start = words_sent;
      while (words_sent - start < ((rates[p] > 8) ? 40 : 95)) random_step();
    end
    no_stall = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    no_stall = 1'b0;
    ready_hold = 0;
    cycles = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    ticks_sent = 0;
    seconds_advanced = 0;
    alarms_fired = 0;
    rate_reg = TpsReset;
    prescale = '0;
    foreach (now_dig[i]) now_dig[i] = '0;
    foreach (alarm_dig[i]) alarm_dig[i] = '0;
    time_set = 1'b0;
    alarm_en = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_rate();
    test_directed();
    test_prescaler_wrap();
    test_random();

    settle();
    repeat (4) @(posedge clk_i);
    $display("Checked %0d of %0d words; %0d ticks, %0d second carries, %0d alarm hits.",
             words_checked, words_sent, ticks_sent, seconds_advanced, alarms_fired);
    $display("Rates 1000, 1..7, 0 and 65535, a lowered rate and BCD rollover exercised.");
    if (mismatches == 0) begin
      $display("tb_bcd_clock_with_alarm OK");
    end else begin
      $display("tb_bcd_clock_with_alarm NOT OK");
    end
    $finish;
  end

endmodule
